>>> hw/rtl/ialu_pkg.sv
// ----------------------------------------------------------------------------
// ialu_pkg
// shared constants and operation codes of the integer alu with power
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int DATA_WIDTH_DEF = 64;
  localparam int IO_WIDTH       = 64;
  localparam int OP_WIDTH       = 4;

  localparam logic [OP_WIDTH-1:0] OP_ADD  = 4'd0;
  localparam logic [OP_WIDTH-1:0] OP_DIV  = 4'd1;
  localparam logic [OP_WIDTH-1:0] OP_POW  = 4'd2;
  localparam logic [OP_WIDTH-1:0] OP_MUL  = 4'd3;
  localparam logic [OP_WIDTH-1:0] OP_SUB  = 4'd4;
  localparam logic [OP_WIDTH-1:0] OP_AND  = 4'd5;
  localparam logic [OP_WIDTH-1:0] OP_OR   = 4'd6;
  localparam logic [OP_WIDTH-1:0] OP_EQV  = 4'd7;
  localparam logic [OP_WIDTH-1:0] OP_NEQV = 4'd8;
  localparam logic [OP_WIDTH-1:0] OP_EQ   = 4'd9;
  localparam logic [OP_WIDTH-1:0] OP_GE   = 4'd10;
  localparam logic [OP_WIDTH-1:0] OP_GT   = 4'd11;
  localparam logic [OP_WIDTH-1:0] OP_LE   = 4'd12;
  localparam logic [OP_WIDTH-1:0] OP_LT   = 4'd13;
  localparam logic [OP_WIDTH-1:0] OP_NE   = 4'd14;

endpackage

>>> hw/rtl/integer_alu_with_power.sv
// ----------------------------------------------------------------------------
// integer_alu_with_power
// integer alu: add, sub, mul, signed divide, power, logic ops and compares
//
// channel  direction  handshake                  payload
// in       input      in_valid / in_stall        in_op, in_left_operand,
//                                                in_right_operand,
//                                                in_unsigned_compare
// out      output     out_valid / out_stall      out_result_word, out_error_flag
//
// one item at a time; in_stall is high from accept until the result is
// loaded into the output register
// add, sub, logic ops and compares finish in S_EXEC; mul waits in S_MUL for the
// shared multiplier; divide makes one quotient bit per cycle in S_DIV, then fixes
// the sign in S_DIVFIX; power skips leading zero exponent bits in S_POW_BIT, then
// squares and, for each set bit, multiplies on the shared multiplier
// synchronous active-low reset clears control state; a stalled output holds
// ----------------------------------------------------------------------------
module integer_alu_with_power #(
  parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ialu_pkg::OP_WIDTH-1:0]       in_op,
  input  logic signed [ialu_pkg::IO_WIDTH-1:0] in_left_operand,
  input  logic signed [ialu_pkg::IO_WIDTH-1:0] in_right_operand,
  input  logic                                in_unsigned_compare,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [ialu_pkg::IO_WIDTH-1:0] out_result_word,
  output logic                                out_error_flag
);

  localparam int W  = DATA_WIDTH;
  localparam int IW = $clog2(W);
  localparam logic [W-1:0] ONE  = {{(W-1){1'b0}}, 1'b1};
  localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONES = {W{1'b1}};
  localparam logic [IW-1:0] LAST_IDX = IW'(W - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_DIVFIX,
    S_POW_BIT,
    S_POW_SQ,
    S_POW_MUL,
    S_MUL,
    S_OUT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [ialu_pkg::OP_WIDTH-1:0]   op_r, op_nxt;
  logic                            uns_r, uns_nxt;
  logic [W-1:0]                    a_r, a_nxt;
  logic [W-1:0]                    b_r, b_nxt;
  logic [W-1:0]                    acc_r, acc_nxt;
  logic [W-1:0]                    quo_r, quo_nxt;
  logic [W-1:0]                    rem_r, rem_nxt;
  logic [W-1:0]                    dvs_r, dvs_nxt;
  logic                            neg_r, neg_nxt;
  logic                            started_r, started_nxt;
  logic [IW-1:0]                   idx_r, idx_nxt;
  logic [W-1:0]                    res_r, res_nxt;
  logic                            err_r, err_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [W-1:0]                    out_res_r, out_res_nxt;
  logic                            out_err_r, out_err_nxt;

  logic                            in_fire;
  logic [W-1:0]                    ca, cb;
  logic [W-1:0]                    a_mag, b_mag;
  logic [W:0]                      trial, diff;
  logic                            step_done;
  logic [W-1:0]                    step_val;
  logic                            mul_start;
  logic [W-1:0]                    mul_a, mul_b;
  logic                            mul_done;
  logic [W-1:0]                    mul_prod;

  ialu_mul #(
    .DATA_WIDTH(W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;

  assign ca    = a_r ^ (uns_r ? {W{1'b0}} : SIGN);
  assign cb    = b_r ^ (uns_r ? {W{1'b0}} : SIGN);
  assign a_mag = a_r[W-1] ? (~a_r + ONE) : a_r;
  assign b_mag = b_r[W-1] ? (~b_r + ONE) : b_r;
  assign trial = {rem_r, quo_r[W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    uns_nxt       = uns_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    acc_nxt       = acc_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    neg_nxt       = neg_r;
    started_nxt   = started_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_res_nxt   = out_res_r;
    out_err_nxt   = out_err_r;
    step_done     = 1'b0;
    step_val      = acc_r;
    mul_start     = 1'b0;
    mul_a         = acc_r;
    mul_b         = acc_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_op;
          uns_nxt   = in_unsigned_compare;
          a_nxt     = in_left_operand[W-1:0];
          b_nxt     = in_right_operand[W-1:0];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        err_nxt   = 1'b0;
        res_nxt   = {W{1'b0}};
        state_nxt = S_OUT;
        case (op_r)
          ialu_pkg::OP_ADD:  res_nxt = a_r + b_r;
          ialu_pkg::OP_SUB:  res_nxt = a_r - b_r;
          ialu_pkg::OP_AND:  res_nxt = a_r & b_r;
          ialu_pkg::OP_OR:   res_nxt = a_r | b_r;
          ialu_pkg::OP_EQV:  res_nxt = ~(a_r ^ b_r);
          ialu_pkg::OP_NEQV: res_nxt = a_r ^ b_r;
          ialu_pkg::OP_EQ:   res_nxt = (ca == cb) ? ONES : {W{1'b0}};
          ialu_pkg::OP_GE:   res_nxt = (ca >= cb) ? ONES : {W{1'b0}};
          ialu_pkg::OP_GT:   res_nxt = (ca > cb)  ? ONES : {W{1'b0}};
          ialu_pkg::OP_LE:   res_nxt = (ca <= cb) ? ONES : {W{1'b0}};
          ialu_pkg::OP_LT:   res_nxt = (ca < cb)  ? ONES : {W{1'b0}};
          ialu_pkg::OP_NE:   res_nxt = (ca != cb) ? ONES : {W{1'b0}};
          ialu_pkg::OP_MUL: begin
            mul_start = 1'b1;
            mul_a     = a_r;
            mul_b     = b_r;
            state_nxt = S_MUL;
          end
          ialu_pkg::OP_DIV: begin
            if (b_r == {W{1'b0}}) begin
              err_nxt = 1'b1;
            end else begin
              quo_nxt   = a_mag;
              rem_nxt   = {W{1'b0}};
              dvs_nxt   = b_mag;
              neg_nxt   = a_r[W-1] ^ b_r[W-1];
              idx_nxt   = LAST_IDX;
              state_nxt = S_DIV;
            end
          end
          ialu_pkg::OP_POW: begin
            if (b_r[W-1]) begin
              if (a_r == ONE) begin
                res_nxt = ONE;
              end else if (a_r == ONES) begin
                res_nxt = b_r[0] ? ONES : ONE;
              end else if (a_r == {W{1'b0}}) begin
                err_nxt = 1'b1;
              end
            end else begin
              acc_nxt     = ONE;
              started_nxt = 1'b0;
              idx_nxt     = LAST_IDX;
              state_nxt   = S_POW_BIT;
            end
          end
          default: res_nxt = {W{1'b0}};
        endcase
      end
      S_DIV: begin
        if (!diff[W]) begin
          rem_nxt = diff[W-1:0];
          quo_nxt = {quo_r[W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[W-1:0];
          quo_nxt = {quo_r[W-2:0], 1'b0};
        end
        if (idx_r == '0) begin
          state_nxt = S_DIVFIX;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      S_DIVFIX: begin
        res_nxt   = neg_r ? (~quo_r + ONE) : quo_r;
        state_nxt = S_OUT;
      end
      S_POW_BIT: begin
        if (started_r) begin
          mul_start = 1'b1;
          state_nxt = S_POW_SQ;
        end else begin
          step_done = 1'b1;
          if (b_r[idx_r]) begin
            started_nxt = 1'b1;
            step_val    = a_r;
          end
        end
      end
      S_POW_SQ: begin
        if (mul_done) begin
          acc_nxt = mul_prod;
          if (b_r[idx_r]) begin
            mul_start = 1'b1;
            mul_a     = mul_prod;
            mul_b     = a_r;
            state_nxt = S_POW_MUL;
          end else begin
            step_done = 1'b1;
            step_val  = mul_prod;
          end
        end
      end
      S_POW_MUL: begin
        if (mul_done) begin
          step_done = 1'b1;
          step_val  = mul_prod;
        end
      end
      S_MUL: begin
        if (mul_done) begin
          res_nxt   = mul_prod;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (step_done) begin
      acc_nxt = step_val;
      if (idx_r == '0) begin
        res_nxt   = step_val;
        state_nxt = S_OUT;
      end else begin
        idx_nxt   = idx_r - 1'b1;
        state_nxt = S_POW_BIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    uns_r     <= uns_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    acc_r     <= acc_nxt;
    quo_r     <= quo_nxt;
    rem_r     <= rem_nxt;
    dvs_r     <= dvs_nxt;
    neg_r     <= neg_nxt;
    started_r <= started_nxt;
    idx_r     <= idx_nxt;
    res_r     <= res_nxt;
    err_r     <= err_nxt;
    out_res_r <= out_res_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_error_flag = out_err_r;

  generate
    if (W < ialu_pkg::IO_WIDTH) begin : g_sext
      assign out_result_word = {{(ialu_pkg::IO_WIDTH - W){out_res_r[W-1]}}, out_res_r};
    end else begin : g_full
      assign out_result_word = out_res_r;
    end
  endgenerate

  // an accepted item always starts execution in the next cycle
  a_accept_exec : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted item did not start execution");

  // the multiplier only answers while the sequencer waits for it
  a_mul_done_wait : assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_MUL || state_r == S_POW_SQ || state_r == S_POW_MUL))
    else $error("multiplier result arrived outside a wait state");

  // the divide loop never runs with a zero divisor
  a_div_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dvs_r != {W{1'b0}}))
    else $error("divide loop entered with zero divisor");

endmodule

>>> hw/rtl/ialu_mul.sv
// ----------------------------------------------------------------------------
// ialu_mul
// wrapping multiplier built from one shared half-width multiplier over
// three partial products, result valid in the cycle after the last phase
// ----------------------------------------------------------------------------
module ialu_mul #(
  parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] op_a,
  input  logic [DATA_WIDTH-1:0] op_b,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] product
);

  localparam int W    = DATA_WIDTH;
  localparam int HALF = (W + 1) / 2;
  localparam int HW   = W - HALF;

  typedef enum logic [2:0] {
    P_IDLE,
    P_LL,
    P_LH,
    P_HL,
    P_SUM
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [W-1:0]        a_r, a_nxt;
  logic [W-1:0]        b_r, b_nxt;
  logic [W-1:0]        acc_r, acc_nxt;
  logic [2*HALF-1:0]   pp_r, pp_nxt;
  logic                done_r, done_nxt;

  logic [HALF-1:0]     a_lo, a_hi, b_lo, b_hi;
  logic [HALF-1:0]     m_x, m_y;
  logic [W-1:0]        pp_shift;

  assign a_lo     = a_r[HALF-1:0];
  assign a_hi     = HALF'(a_r[W-1:HALF]);
  assign b_lo     = b_r[HALF-1:0];
  assign b_hi     = HALF'(b_r[W-1:HALF]);
  assign pp_shift = {pp_r[HW-1:0], {HALF{1'b0}}};

  always_comb begin
    phase_nxt = phase_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    done_nxt  = 1'b0;
    m_x       = a_lo;
    m_y       = b_lo;
    case (phase_r)
      P_IDLE: begin
        if (start) begin
          a_nxt     = op_a;
          b_nxt     = op_b;
          phase_nxt = P_LL;
        end
      end
      P_LL: begin
        phase_nxt = P_LH;
      end
      P_LH: begin
        m_y       = b_hi;
        acc_nxt   = pp_r[W-1:0];
        phase_nxt = P_HL;
      end
      P_HL: begin
        m_x       = a_hi;
        acc_nxt   = acc_r + pp_shift;
        phase_nxt = P_SUM;
      end
      P_SUM: begin
        acc_nxt   = acc_r + pp_shift;
        done_nxt  = 1'b1;
        phase_nxt = P_IDLE;
      end
      default: begin
        phase_nxt = P_IDLE;
      end
    endcase
    pp_nxt = {{HALF{1'b0}}, m_x} * {{HALF{1'b0}}, m_y};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
    pp_r  <= pp_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule
